// ===== src/lhi_pkg.sv =====
// Shared types, constants and helper functions of the lattice height interpolator.
// Used by lhi_lerp_finish and lattice_height_interpolator_unit; depends on nothing.
package lhi_pkg;

   localparam int HEIGHT_LEVELS = 8;
   localparam int HEIGHT_MAX_INT = (HEIGHT_LEVELS - 1 > 7) ? 7 : HEIGHT_LEVELS - 1;
   localparam logic [2:0] HEIGHT_MAX = 3'(HEIGHT_MAX_INT);
   localparam logic [4:0] SEP_RESET = 5'd4;

   // One interpolation step, half done: start point, direction and the
   // ceiling-division numerator k*|b-a| + sep - 1.
   typedef struct packed {
      logic [2:0] base;
      logic       down;
      logic [7:0] num;
   } step_type;

   typedef struct packed {
      logic [1:0] red;
      logic [1:0] green;
      logic [1:0] blue;
   } color_type;

   function automatic logic [2:0] clamp_height(input logic [2:0] h);
      return (h > HEIGHT_MAX) ? HEIGHT_MAX : h;
   endfunction

   function automatic step_type make_step(input logic [2:0] a, input logic [2:0] b,
                                          input logic [3:0] k, input logic [4:0] sep_m1);
      step_type   s;
      logic [2:0] diff;
      logic [6:0] prod;
      s.base = a;
      s.down = (a > b);
      diff   = (a > b) ? (a - b) : (b - a);
      prod   = 7'(k) * 7'(diff);
      s.num  = 8'(prod) + 8'(sep_m1);
      return s;
   endfunction

   function automatic color_type palette(input logic [2:0] h);
      color_type c;
      unique case (h)
         3'd0: c = '{2'd0, 2'd1, 2'd3};
         3'd1: c = '{2'd0, 2'd1, 2'd2};
         3'd2: c = '{2'd0, 2'd2, 2'd1};
         3'd3: c = '{2'd0, 2'd1, 2'd0};
         3'd4: c = '{2'd1, 2'd1, 2'd0};
         3'd5: c = '{2'd2, 2'd2, 2'd1};
         3'd6: c = '{2'd2, 2'd2, 2'd2};
         3'd7: c = '{2'd3, 2'd3, 2'd3};
      endcase
      return c;
   endfunction

endpackage

// ===== src/lattice_height_interpolator_unit.sv =====
// Top level of the lattice height interpolator: four-stage pipeline with
// spacing register. Uses lhi_pkg and lhi_lerp_finish.
//
// Usage: a transaction on req_ carries the four corner heights of a lattice
// cell and the pixel's offsets from its upper-left corner; each one yields
// exactly one transaction on rsp_ with the pixel height and palette color.
// The csr_ port writes the lattice spacing (0 acts as 1); write it only
// while the pipeline is empty.
// The accepting edge loads stage 1 (column numerators); the transaction then
// passes column division, row numerator and row division plus palette;
// rsp_valid rises when it reaches stage 4. Throughput: one transaction per
// cycle while rsp_ready is high; each stage advances when the next frees up.
// Reset empties all stages and sets the spacing to 4.
// When the receiver stalls, the result holds in the last stage and earlier
// stages keep filling bubbles; req_ready drops only once all four stages
// hold a transaction.
module lattice_height_interpolator_unit (
   input  logic       clock,
   input  logic       reset,
   input  logic       csr_wr_en,
   input  logic [4:0] csr_wr_data,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [2:0] req_top_left_height,
   input  logic [2:0] req_bottom_left_height,
   input  logic [2:0] req_top_right_height,
   input  logic [2:0] req_bottom_right_height,
   input  logic [3:0] req_offset_across,
   input  logic [3:0] req_offset_down,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [2:0] rsp_height,
   output logic [1:0] rsp_red,
   output logic [1:0] rsp_green,
   output logic [1:0] rsp_blue
);
   import lhi_pkg::*;

   logic [4:0] sep_ff, sep_in;
   logic [4:0] sep_eff, sep_m1;

   logic       v1_ff, v2_ff, v3_ff, v4_ff;
   logic       v1_in, v2_in, v3_in, v4_in;
   logic       adv1, adv2, adv3, adv4;

   step_type   left_ff, right_ff, left_in, right_in;
   logic [3:0] kx1_ff, kx1_in, kx2_ff;
   logic [2:0] left2_ff, right2_ff, left2_in, right2_in;
   step_type   row_ff, row_in;
   logic [2:0] height_ff, height_in;
   color_type  color_ff, color_in;

   logic [3:0] kx_sat, ky_sat;

   // Spacing register
   always_comb begin
      sep_in  = csr_wr_en ? csr_wr_data : sep_ff;
      sep_eff = (sep_ff == 5'd0) ? 5'd1 : sep_ff;
      sep_m1  = sep_eff - 5'd1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sep_ff <= SEP_RESET;
      end else begin
         sep_ff <= sep_in;
      end
   end

   // Stall control: a stage advances when empty or when the next one advances
   always_comb begin
      adv4      = !v4_ff || rsp_ready;
      adv3      = !v3_ff || adv4;
      adv2      = !v2_ff || adv3;
      adv1      = !v1_ff || adv2;
      req_ready = adv1;
      v1_in     = adv1 ? req_valid : v1_ff;
      v2_in     = adv2 ? v1_ff : v2_ff;
      v3_in     = adv3 ? v2_ff : v3_ff;
      v4_in     = adv4 ? v3_ff : v4_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         v1_ff <= v1_in;
         v2_ff <= v2_in;
         v3_ff <= v3_in;
         v4_ff <= v4_in;
      end
   end

   // Stage 1: clamp, saturate offsets, build column numerators
   always_comb begin
      kx_sat   = ({1'b0, req_offset_across} >= sep_eff) ? 4'(sep_m1) : req_offset_across;
      ky_sat   = ({1'b0, req_offset_down} >= sep_eff) ? 4'(sep_m1) : req_offset_down;
      left_in  = make_step(clamp_height(req_top_left_height),
                           clamp_height(req_bottom_left_height), ky_sat, sep_m1);
      right_in = make_step(clamp_height(req_top_right_height),
                           clamp_height(req_bottom_right_height), ky_sat, sep_m1);
      kx1_in   = kx_sat;
   end

   always_ff @(posedge clock) begin
      if (adv1) begin
         left_ff  <= left_in;
         right_ff <= right_in;
         kx1_ff   <= kx1_in;
      end
   end

   // Stage 2: column divisions
   lhi_lerp_finish u_left_div (
      .step_in (left_ff),
      .sep     (sep_eff),
      .result  (left2_in)
   );

   lhi_lerp_finish u_right_div (
      .step_in (right_ff),
      .sep     (sep_eff),
      .result  (right2_in)
   );

   always_ff @(posedge clock) begin
      if (adv2) begin
         left2_ff  <= left2_in;
         right2_ff <= right2_in;
         kx2_ff    <= kx1_ff;
      end
   end

   // Stage 3: row numerator
   assign row_in = make_step(left2_ff, right2_ff, kx2_ff, sep_m1);

   always_ff @(posedge clock) begin
      if (adv3) begin
         row_ff <= row_in;
      end
   end

   // Stage 4: row division and palette lookup
   lhi_lerp_finish u_row_div (
      .step_in (row_ff),
      .sep     (sep_eff),
      .result  (height_in)
   );

   assign color_in = palette(height_in);

   always_ff @(posedge clock) begin
      if (adv4) begin
         height_ff <= height_in;
         color_ff  <= color_in;
      end
   end

   assign rsp_valid  = v4_ff;
   assign rsp_height = height_ff;
   assign rsp_red    = color_ff.red;
   assign rsp_green  = color_ff.green;
   assign rsp_blue   = color_ff.blue;

   // Backpressure reaches the input only when every stage is full
   a_ready_full: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> (v1_ff && v2_ff && v3_ff && v4_ff))
      else $error("req_ready low with a bubble in the pipeline");

   a_out_from_stage3: assert property (@(posedge clock) disable iff (reset)
      $rose(v4_ff) |-> $past(v3_ff))
      else $error("result appeared without a transaction in stage 3");

   a_color_matches: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (color_ff == palette(height_ff)))
      else $error("palette color does not match height");

endmodule

// ===== src/lhi_lerp_finish.sv =====
// Second half of one interpolation step: three-bit restoring ceiling division
// by the spacing, then step from the base toward the far point. Uses lhi_pkg.
module lhi_lerp_finish (
   input  lhi_pkg::step_type step_in,
   input  logic [4:0]        sep,
   output logic [2:0]        result
);
   import lhi_pkg::*;

   logic [7:0] div4, div2, div1;
   logic [7:0] rem2, rem1;
   logic [2:0] quot;

   // Quotient never exceeds |b-a| since k < sep, so three bits suffice.
   always_comb begin
      div4    = {1'b0, sep, 2'b00};
      div2    = {2'b00, sep, 1'b0};
      div1    = {3'b000, sep};
      quot[2] = (step_in.num >= div4);
      rem2    = quot[2] ? (step_in.num - div4) : step_in.num;
      quot[1] = (rem2 >= div2);
      rem1    = quot[1] ? (rem2 - div2) : rem2;
      quot[0] = (rem1 >= div1);
      result  = step_in.down ? (step_in.base - quot) : (step_in.base + quot);
   end

endmodule
